// ===== rtl/rsr_pkg.sv =====
// shared types, constants and helpers of the linear resampler with filter stages
// used by every module of the block except the queue; depends on nothing

package rsr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_RESULTS = 64;
   localparam int SAT_W       = 36;
   localparam int LP_SHIFT    = 7;
   localparam int BQ_SHIFT    = 15;
   localparam int UNITY_SHIFT = 12;

   localparam logic [15:0] PITCH_RESET = 16'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PITCH         = 3'd0,
      CSR_LOWPASS_COEFF = 3'd1,
      CSR_BIQUAD_ENABLE = 3'd2,
      CSR_COEF_B1       = 3'd3,
      CSR_COEF_B2       = 3'd4,
      CSR_COEF_A1       = 3'd5,
      CSR_COEF_A2       = 3'd6
   } rsr_csr_index_type;

   typedef struct packed {
      logic        [15:0] pitch;
      logic signed [15:0] lowpass_coeff;
      logic               biquad_enable;
      logic signed [15:0] coef_b1;
      logic signed [15:0] coef_b2;
      logic signed [15:0] coef_a1;
      logic signed [15:0] coef_a2;
   } rsr_cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] source_sample;
      logic                       restart;
   } rsr_cmd_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       last_of_run;
   } rsr_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INTERP_MUL,
      ST_INTERP_ADD,
      ST_LP_MUL,
      ST_LP_ADD,
      ST_BQ_B1,
      ST_BQ_B2,
      ST_BQ_A1,
      ST_BQ_A2,
      ST_BQ_SUM,
      ST_EMIT,
      ST_FINISH
   } rsr_state_type;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > SAT_W'(32767)) begin
         r = 16'sh7fff;
      end else if (v < -SAT_W'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/rsr_queue.sv =====
// small first-in first-out queue built from registers, push/full and pop/empty
// generic; used for the command queue and the result queue, no package needed

module rsr_queue #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage words carry payload only
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/rsr_csr.sv =====
// configuration register file, one write beat per register
// depends on rsr_pkg for the register indexes and the configuration struct

module rsr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rsr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output rsr_pkg::rsr_cfg_type                cfg
);

   rsr_pkg::rsr_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rsr_pkg::CSR_PITCH:         cfg_in.pitch         = csr_wdata;
            rsr_pkg::CSR_LOWPASS_COEFF: cfg_in.lowpass_coeff = csr_wdata;
            rsr_pkg::CSR_BIQUAD_ENABLE: cfg_in.biquad_enable = csr_wdata[0];
            rsr_pkg::CSR_COEF_B1:       cfg_in.coef_b1       = csr_wdata;
            rsr_pkg::CSR_COEF_B2:       cfg_in.coef_b2       = csr_wdata;
            rsr_pkg::CSR_COEF_A1:       cfg_in.coef_a1       = csr_wdata;
            rsr_pkg::CSR_COEF_A2:       cfg_in.coef_a2       = csr_wdata;
            default:                    cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch         <= rsr_pkg::PITCH_RESET;
         cfg_ff.lowpass_coeff <= '0;
         cfg_ff.biquad_enable <= 1'b0;
         cfg_ff.coef_b1       <= '0;
         cfg_ff.coef_b2       <= '0;
         cfg_ff.coef_a1       <= '0;
         cfg_ff.coef_a2       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/rsr_engine.sv =====
// back end: phase accumulator, interpolation and both filter stages on one
// shared multiplier, stepped by a sequencer; depends on rsr_pkg

module rsr_engine #(
   parameter int PHASE_FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsr_pkg::rsr_cfg_type cfg,
   input  logic                 cmd_empty,
   input  rsr_pkg::rsr_cmd_type cmd_data,
   output logic                 cmd_pop,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output rsr_pkg::rsr_rsp_type rsp_data
);

   localparam int PHASE_W = PHASE_FRAC_BITS + 5;
   localparam int STEP_W  = PHASE_FRAC_BITS + 4;
   localparam int MUL_W   = (PHASE_FRAC_BITS + 1 > 17) ? PHASE_FRAC_BITS + 1 : 17;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int RUN_W   = $clog2(rsr_pkg::MAX_RESULTS);
   localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << PHASE_FRAC_BITS;

   rsr_pkg::rsr_state_type state_ff, state_in;

   logic        [PHASE_W-1:0] phase_ff, phase_in;
   logic signed [15:0]        prev_ff, prev_in;
   logic signed [15:0]        next_ff, next_in;
   logic signed [16:0]        diff_ff, diff_in;
   logic signed [15:0]        x_ff, x_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic        [RUN_W-1:0]   run_ff, run_in;
   logic signed [15:0]        lp_in_ff, lp_in_in;
   logic signed [15:0]        lp_out_ff, lp_out_in;
   logic signed [15:0]        bq_in1_ff, bq_in1_in;
   logic signed [15:0]        bq_in2_ff, bq_in2_in;
   logic signed [15:0]        bq_out1_ff, bq_out1_in;
   logic signed [15:0]        bq_out2_ff, bq_out2_in;

   logic [PHASE_FRAC_BITS+15:0] step_wide;
   logic [STEP_W-1:0]           step;
   logic [PHASE_W-1:0]          phase_sum;
   logic                        phase_ge_one, sum_ge_one, run_last, emit_last;
   logic                        lp_on, bq_on;
   logic signed [MUL_W-1:0]     mul_a, mul_b;
   logic signed [PROD_W-1:0]    mul_p;
   logic signed [16:0]          lp_delta;
   logic signed [PROD_W-1:0]    interp_shift;
   logic signed [17:0]          interp_sum;
   logic signed [15:0]          lp_o, bq_o;
   logic signed [ACC_W-1:0]     bq_sum;

   // step = pitch scaled from 12 fraction bits to the phase format
   assign step_wide    = {cfg.pitch, {PHASE_FRAC_BITS{1'b0}}};
   assign step         = step_wide[PHASE_FRAC_BITS+15:rsr_pkg::UNITY_SHIFT];
   assign phase_sum    = phase_ff + PHASE_W'(step);
   assign phase_ge_one = |phase_ff[PHASE_W-1:PHASE_FRAC_BITS];
   assign sum_ge_one   = |phase_sum[PHASE_W-1:PHASE_FRAC_BITS];
   assign run_last     = (run_ff == RUN_W'(rsr_pkg::MAX_RESULTS - 1));
   assign emit_last    = sum_ge_one | run_last;
   assign lp_on        = (cfg.lowpass_coeff != '0);
   assign bq_on        = cfg.biquad_enable;

   assign lp_delta     = 17'(x_ff) - 17'(lp_in_ff);
   assign interp_shift = prod_ff >>> PHASE_FRAC_BITS;
   assign interp_sum   = 18'(interp_shift) + 18'(prev_ff);
   assign lp_o         = rsr_pkg::sat16(rsr_pkg::SAT_W'(prod_ff >>> rsr_pkg::LP_SHIFT)
                                        + rsr_pkg::SAT_W'(lp_out_ff));
   assign bq_sum       = acc_ff + ACC_W'(prod_ff);
   assign bq_o         = rsr_pkg::sat16(rsr_pkg::SAT_W'(bq_sum >>> rsr_pkg::BQ_SHIFT));

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         rsr_pkg::ST_INTERP_MUL: begin
            mul_a = MUL_W'({1'b0, phase_ff[PHASE_FRAC_BITS-1:0]});
            mul_b = MUL_W'(diff_ff);
         end
         rsr_pkg::ST_LP_MUL: begin
            mul_a = MUL_W'(lp_delta);
            mul_b = MUL_W'(cfg.lowpass_coeff);
         end
         rsr_pkg::ST_BQ_B1: begin
            mul_a = MUL_W'(bq_in1_ff);
            mul_b = MUL_W'(cfg.coef_b1);
         end
         rsr_pkg::ST_BQ_B2: begin
            mul_a = MUL_W'(bq_in2_ff);
            mul_b = MUL_W'(cfg.coef_b2);
         end
         rsr_pkg::ST_BQ_A1: begin
            mul_a = MUL_W'(bq_out1_ff);
            mul_b = MUL_W'(cfg.coef_a1);
         end
         rsr_pkg::ST_BQ_A2: begin
            mul_a = MUL_W'(bq_out2_ff);
            mul_b = MUL_W'(cfg.coef_a2);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsr_pkg::ST_IDLE:       if (!cmd_empty) state_in = rsr_pkg::ST_CHECK;
         rsr_pkg::ST_CHECK:      state_in = phase_ge_one ? rsr_pkg::ST_FINISH
                                                         : rsr_pkg::ST_INTERP_MUL;
         rsr_pkg::ST_INTERP_MUL: state_in = rsr_pkg::ST_INTERP_ADD;
         rsr_pkg::ST_INTERP_ADD: begin
            if (lp_on) begin
               state_in = rsr_pkg::ST_LP_MUL;
            end else if (bq_on) begin
               state_in = rsr_pkg::ST_BQ_B1;
            end else begin
               state_in = rsr_pkg::ST_EMIT;
            end
         end
         rsr_pkg::ST_LP_MUL:     state_in = rsr_pkg::ST_LP_ADD;
         rsr_pkg::ST_LP_ADD:     state_in = bq_on ? rsr_pkg::ST_BQ_B1 : rsr_pkg::ST_EMIT;
         rsr_pkg::ST_BQ_B1:      state_in = rsr_pkg::ST_BQ_B2;
         rsr_pkg::ST_BQ_B2:      state_in = rsr_pkg::ST_BQ_A1;
         rsr_pkg::ST_BQ_A1:      state_in = rsr_pkg::ST_BQ_A2;
         rsr_pkg::ST_BQ_A2:      state_in = rsr_pkg::ST_BQ_SUM;
         rsr_pkg::ST_BQ_SUM:     state_in = rsr_pkg::ST_EMIT;
         rsr_pkg::ST_EMIT: begin
            if (!rsp_full) begin
               state_in = emit_last ? rsr_pkg::ST_FINISH : rsr_pkg::ST_INTERP_MUL;
            end
         end
         rsr_pkg::ST_FINISH:     state_in = rsr_pkg::ST_IDLE;
         default:                state_in = rsr_pkg::ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      cmd_pop             = 1'b0;
      rsp_push            = 1'b0;
      rsp_data.out_sample  = x_ff;
      rsp_data.last_of_run = emit_last;
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      next_in    = next_ff;
      diff_in    = diff_ff;
      x_in       = x_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      run_in     = run_ff;
      lp_in_in   = lp_in_ff;
      lp_out_in  = lp_out_ff;
      bq_in1_in  = bq_in1_ff;
      bq_in2_in  = bq_in2_ff;
      bq_out1_in = bq_out1_ff;
      bq_out2_in = bq_out2_ff;
      case (state_ff)
         rsr_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               next_in = cmd_data.source_sample;
               if (cmd_data.restart) begin
                  phase_in   = '0;
                  prev_in    = '0;
                  lp_in_in   = '0;
                  lp_out_in  = '0;
                  bq_in1_in  = '0;
                  bq_in2_in  = '0;
                  bq_out1_in = '0;
                  bq_out2_in = '0;
               end
            end
         end
         rsr_pkg::ST_CHECK: begin
            diff_in = 17'(next_ff) - 17'(prev_ff);
            run_in  = '0;
         end
         rsr_pkg::ST_INTERP_MUL: prod_in = mul_p;
         rsr_pkg::ST_INTERP_ADD: x_in = interp_sum[15:0];
         rsr_pkg::ST_LP_MUL:     prod_in = mul_p;
         rsr_pkg::ST_LP_ADD: begin
            lp_in_in  = x_ff;
            lp_out_in = lp_o;
            x_in      = lp_o;
         end
         rsr_pkg::ST_BQ_B1: begin
            prod_in = mul_p;
            acc_in  = '0;
         end
         rsr_pkg::ST_BQ_B2, rsr_pkg::ST_BQ_A1, rsr_pkg::ST_BQ_A2: begin
            prod_in = mul_p;
            acc_in  = bq_sum;
         end
         rsr_pkg::ST_BQ_SUM: begin
            bq_in2_in  = bq_in1_ff;
            bq_in1_in  = x_ff;
            bq_out2_in = bq_out1_ff;
            bq_out1_in = bq_o;
            x_in       = bq_o;
         end
         rsr_pkg::ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               phase_in = phase_sum;
               run_in   = run_ff + 1'b1;
            end
         end
         rsr_pkg::ST_FINISH: begin
            phase_in = phase_ge_one ? phase_ff - ONE : '0;
            prev_in  = next_ff;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rsr_pkg::ST_IDLE;
         phase_ff   <= '0;
         prev_ff    <= '0;
         run_ff     <= '0;
         lp_in_ff   <= '0;
         lp_out_ff  <= '0;
         bq_in1_ff  <= '0;
         bq_in2_ff  <= '0;
         bq_out1_ff <= '0;
         bq_out2_ff <= '0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         prev_ff    <= prev_in;
         run_ff     <= run_in;
         lp_in_ff   <= lp_in_in;
         lp_out_ff  <= lp_out_in;
         bq_in1_ff  <= bq_in1_in;
         bq_in2_ff  <= bq_in2_in;
         bq_out1_ff <= bq_out1_in;
         bq_out2_ff <= bq_out2_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff <= next_in;
      diff_ff <= diff_in;
      x_ff    <= x_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

// ===== rtl/linear_resampler_iir_filter.sv =====
// top level of the linear resampler with first-order and recursive filter stages
// depends on rsr_pkg, rsr_queue, rsr_csr and rsr_engine

// Each input beat carries one signed 16-bit source sample and a restart flag;
// it causes zero to 64 result beats, the last one marked by last_of_run. The
// sample is interpolated against the previous one at a 4.12 pitch step, then
// passes the optional first-order stage (lowpass_coeff nonzero) and the
// optional recursive stage (biquad_enable), both saturating to 16 bits.
// Input beats go into a command queue and results leave through a result
// queue, so both sides may stall freely. One shared 17x17 multiplier, stepped
// by a sequencer, serves the interpolation multiply and add, the first-order
// multiply and add and the b1, b2, a1, a2 products and sum (stages only when
// on), emit waits for room; each input beat adds fetch, check and phase wrap.
// Configuration writes are always taken and must only happen while idle.

module linear_resampler_iir_filter #(
   parameter int PHASE_FRAC_BITS = 12,
   parameter int CMD_DEPTH       = 2,
   parameter int RSP_DEPTH       = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // input queue side
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [rsr_pkg::SAMPLE_W-1:0] req_source_sample,
   input  logic                                req_restart,
   // result queue side
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [rsr_pkg::SAMPLE_W-1:0] rsp_out_sample,
   output logic                                rsp_last_of_run,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rsr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CMD_W = $bits(rsr_pkg::rsr_cmd_type);
   localparam int RSP_W = $bits(rsr_pkg::rsr_rsp_type);

   rsr_pkg::rsr_cfg_type cfg;
   rsr_pkg::rsr_cmd_type req_cmd, cmd_data;
   rsr_pkg::rsr_rsp_type eng_rsp, rsp_word;
   logic [CMD_W-1:0]     cmd_q_data;
   logic [RSP_W-1:0]     rsp_q_data;
   logic                 cmd_empty, cmd_pop;
   logic                 rsp_full, rsp_push;

   // front: pack the beat for the command queue
   assign req_cmd.source_sample = req_source_sample;
   assign req_cmd.restart       = req_restart;
   assign cmd_data              = cmd_q_data;

   assign rsp_word        = rsp_q_data;
   assign rsp_out_sample  = rsp_word.out_sample;
   assign rsp_last_of_run = rsp_word.last_of_run;

   rsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // queue between intake and engine
   rsr_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (req_cmd),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd_q_data),
      .empty   (cmd_empty)
   );

   rsr_engine #(
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (eng_rsp)
   );

   // results wait here so the engine keeps going while the consumer stalls, until the queue is full
   rsr_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (eng_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_q_data),
      .empty   (rsp_empty)
   );

endmodule

// ===== rtl/rsr_checker.sv =====
// port-level checks of the resampler top level, attached by bind
// depends on rsr_pkg for the sample width

module rsr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic signed [rsr_pkg::SAMPLE_W-1:0] rsp_out_sample,
   input logic                                rsp_last_of_run
);

   // the result queue comes out of reset empty and the command queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a waiting result beat holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_sample) && $stable(rsp_last_of_run)))
      else $error("waiting result changed");

   // the command queue fills only through a push
   a_full_by_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("input full without push");

   // no result appears in the cycle after reset
   a_no_result_from_reset: assert property (@(posedge clock)
      $fell(rsp_empty) |-> !$past(reset))
      else $error("result right after reset");

endmodule

bind linear_resampler_iir_filter rsr_checker u_rsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_out_sample  (rsp_out_sample),
   .rsp_last_of_run (rsp_last_of_run)
);

// ===== tb/rsr_result_check.sv =====
// result checker for the linear resampler: predicts every result beat and compares
// depends on rsr_pkg; watches the req_, rsp_ and csr_ channels of the block

module rsr_result_check
   import rsr_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic                         req_full,
   input  logic signed [SAMPLE_W-1:0]   req_source_sample,
   input  logic                         req_restart,
   input  logic                         rsp_empty,
   input  logic                         rsp_pop,
   input  logic signed [SAMPLE_W-1:0]   rsp_out_sample,
   input  logic                         rsp_last_of_run,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output int                           fail_count,
   output int                           pending
);

   localparam int unsigned PHASE_ONE       = 1 << PHASE_FRAC_BITS;
   localparam int          LOWPASS_SHIFT   = 7;
   localparam int          RECURSIVE_SHIFT = 15;

   // register copies
   logic        [15:0] pitch;
   logic signed [15:0] lp_coeff;
   logic               bq_on;
   logic signed [15:0] b1, b2, a1, a2;

   // interpolator and filter history
   int unsigned        phase_acc;
   logic signed [15:0] prev_sample;
   logic signed [15:0] lp_in, lp_out;
   logic signed [15:0] bq_in1, bq_in2, bq_out1, bq_out2;

   rsr_rsp_type expected_samples[$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic int unsigned phase_step();
      if (PHASE_FRAC_BITS >= 12) return int'(pitch) << (PHASE_FRAC_BITS - 12);
      return int'(pitch) >> (12 - PHASE_FRAC_BITS);
   endfunction

   function automatic void clear_history();
      phase_acc   = 0;
      prev_sample = '0;
      lp_in       = '0;
      lp_out      = '0;
      bq_in1      = '0;
      bq_in2      = '0;
      bq_out1     = '0;
      bq_out2     = '0;
   endfunction

   // first-order stage, then the recursive one; a stage that is off keeps its history
   function automatic logic signed [15:0] run_stages(input logic signed [15:0] x);
      longint             acc;
      logic signed [15:0] y;
      logic signed [15:0] o;
      y = x;
      if (lp_coeff != 0) begin
         acc = (longint'(y) - longint'(lp_in)) * longint'(lp_coeff);
         o = clamp16((acc >>> LOWPASS_SHIFT) + longint'(lp_out));
         lp_in  = y;
         lp_out = o;
         y = o;
      end
      if (bq_on) begin
         acc = longint'(b1) * longint'(bq_in1) + longint'(b2) * longint'(bq_in2)
             + longint'(a1) * longint'(bq_out1) + longint'(a2) * longint'(bq_out2);
         o = clamp16(acc >>> RECURSIVE_SHIFT);
         bq_in2  = bq_in1;
         bq_in1  = y;
         bq_out2 = bq_out1;
         bq_out1 = o;
         y = o;
      end
      return y;
   endfunction

   function automatic void predict_results(input logic signed [15:0] src, input logic clear_first);
      rsr_rsp_type        beat;
      longint             diff;
      int                 n;
      int unsigned        stp;
      logic signed [15:0] interp;
      if (clear_first) clear_history();
      stp  = phase_step();
      diff = longint'(src) - longint'(prev_sample);
      n    = 0;
      while (phase_acc < PHASE_ONE && n < MAX_RESULTS) begin
         interp = 16'(longint'(prev_sample)
                      + ((longint'(phase_acc) * diff) >>> PHASE_FRAC_BITS));
         beat.out_sample = run_stages(interp);
         phase_acc += stp;
         n++;
         beat.last_of_run = !(phase_acc < PHASE_ONE && n < MAX_RESULTS);
         expected_samples.push_back(beat);
      end
      phase_acc   = (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : 0;
      prev_sample = src;
   endfunction

   always @(posedge clock) begin : watch
      rsr_rsp_type beat;
      if (reset) begin
         pitch    = PITCH_RESET;
         lp_coeff = '0;
         bq_on    = 1'b0;
         b1       = '0;
         b2       = '0;
         a1       = '0;
         a2       = '0;
         clear_history();
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (rsr_csr_index_type'(csr_index))
               CSR_PITCH:         pitch    = csr_wdata;
               CSR_LOWPASS_COEFF: lp_coeff = csr_wdata;
               CSR_BIQUAD_ENABLE: bq_on    = csr_wdata[0];
               CSR_COEF_B1:       b1       = csr_wdata;
               CSR_COEF_B2:       b2       = csr_wdata;
               CSR_COEF_A1:       a1       = csr_wdata;
               CSR_COEF_A2:       a2       = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) predict_results(req_source_sample, req_restart);
         if (rsp_pop && !rsp_empty) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected result beat: out_sample %0d last_of_run %0b",
                      rsp_out_sample, rsp_last_of_run);
               fail_count++;
            end else begin
               beat = expected_samples.pop_front();
               if (rsp_out_sample !== beat.out_sample) begin
                  $error("out_sample: expected %0d, actual %0d",
                         beat.out_sample, rsp_out_sample);
                  fail_count++;
               end
               if (rsp_last_of_run !== beat.last_of_run) begin
                  $error("last_of_run: expected %0b, actual %0b",
                         beat.last_of_run, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
      end
      pending <= expected_samples.size();
   end

endmodule

// ===== tb/linear_resampler_iir_filter_tb.sv =====
// top of the resampler testbench: clock, reset, stimulus, receiver stalls and verdict
// depends on rsr_pkg, the block linear_resampler_iir_filter and rsr_result_check

module linear_resampler_iir_filter_tb;
   import rsr_pkg::*;

   localparam int PHASE_BITS      = 12;
   // slowest correct run: ~200 input beats, each up to 64 results, plus
   // receiver stalls; taken several times over
   localparam int CYCLE_LIMIT     = 2_000_000;
   // a beat that gives no result may still be in the command queue or the engine
   localparam int SETTLE_CYCLES   = 40;
   localparam int RANDOM_PHASES   = 6;
   localparam int BEATS_PER_PHASE = 30;
   localparam int SWAP_IDLE_AT    = 67;
   localparam int STOP_IDLE_AT    = 134;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_push          = 1'b0;
   logic                       req_full;
   logic signed [SAMPLE_W-1:0] req_source_sample = '0;
   logic                       req_restart       = 1'b0;
   logic                       rsp_empty;
   logic                       rsp_pop           = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic                       rsp_last_of_run;
   logic                       csr_valid         = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index         = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata         = '0;

   int fail_count;
   int pending;
   int send_idle_pct = 15;
   int recv_idle_pct = 72;
   int items_sent    = 0;
   int cycle_count   = 0;

   always #2 clock = ~clock;

   linear_resampler_iir_filter #(
      .PHASE_FRAC_BITS(PHASE_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_source_sample (req_source_sample),
      .req_restart       (req_restart),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_sample    (rsp_out_sample),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   rsr_result_check #(
      .PHASE_FRAC_BITS(PHASE_BITS)
   ) result_check (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_source_sample (req_source_sample),
      .req_restart       (req_restart),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_out_sample    (rsp_out_sample),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // receiver: decides afresh every cycle whether to take a result beat
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog, counts rising edges until the limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // one input beat; starts and ends on a falling edge, push stays high for back-to-back beats
   task automatic send_beat(input logic signed [15:0] src, input logic clear_first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push          <= 1'b1;
      req_source_sample <= src;
      req_restart       <= clear_first;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      items_sent++;
      // idling schedule: sender light then receiver light, then none at all
      if (items_sent == SWAP_IDLE_AT) begin
         send_idle_pct = 72;
         recv_idle_pct = 15;
      end else if (items_sent == STOP_IDLE_AT) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // hold the sender until every predicted result has been taken
   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   // valid is left high so that consecutive writes need no gap
   task automatic csr_write(input rsr_csr_index_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // full register set, only once the block has gone quiet
   task automatic write_settings(input logic [15:0] pitch_v, input logic [15:0] lp_v,
                                 input logic bq_v, input logic [15:0] b1_v,
                                 input logic [15:0] b2_v, input logic [15:0] a1_v,
                                 input logic [15:0] a2_v);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write(CSR_PITCH, pitch_v);
      csr_write(CSR_LOWPASS_COEFF, lp_v);
      csr_write(CSR_BIQUAD_ENABLE, {15'd0, bq_v});
      csr_write(CSR_COEF_B1, b1_v);
      csr_write(CSR_COEF_B2, b2_v);
      csr_write(CSR_COEF_A1, a1_v);
      csr_write(CSR_COEF_A2, a2_v);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic        [15:0] pitch_set;
      logic signed [15:0] lp_set, b1_set, b2_set, a1_set, a2_set;
      logic               bq_set;
      logic signed [15:0] src;
      logic signed [15:0] last_src;
      int                 pick;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: unity pitch, both stages bypassed, one result per beat
      send_beat(16'sd0, 1'b0);
      send_beat(SAMPLE_MAX, 1'b0);
      send_beat(SAMPLE_MIN, 1'b0);
      send_beat(SAMPLE_MAX, 1'b0);
      send_beat(-16'sd1, 1'b0);
      send_beat(16'sd1, 1'b1);
      send_beat(SAMPLE_MIN, 1'b0);

      // largest step: most beats find the phase at or above one and give nothing;
      // full gain in the first-order stage drives it into saturation
      write_settings(16'hffff, SAMPLE_MAX, 1'b0, '0, '0, '0, '0);
      send_beat(SAMPLE_MAX, 1'b0);
      send_beat(SAMPLE_MIN, 1'b0);
      send_beat(16'sh5555, 1'b0);
      send_beat(SAMPLE_MIN, 1'b1);
      send_beat(16'shaaaa, 1'b0);
      send_beat(SAMPLE_MAX, 1'b0);

      // step below range: capped at 64 results, phase still below one so it is zeroed;
      // recursive stage on with extreme weights, first-order gain most negative
      write_settings(16'd63, SAMPLE_MIN, 1'b1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
      send_beat(SAMPLE_MAX, 1'b0);
      send_beat(SAMPLE_MIN, 1'b0);
      send_beat(16'sd1234, 1'b1);

      // half step, two results per beat, smallest nonzero first-order gain
      write_settings(16'd2048, 16'sd1, 1'b1, 16'sd16384, -16'sd8192, 16'sd24576, -16'sd12288);
      send_beat(SAMPLE_MIN, 1'b0);
      send_beat(SAMPLE_MAX, 1'b0);
      send_beat(16'sd0, 1'b0);
      send_beat(-16'sd2, 1'b1);

      last_src = '0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         b1_set = 16'($urandom);
         b2_set = 16'($urandom);
         a1_set = 16'($urandom);
         a2_set = 16'($urandom);
         case (ph)
            0: begin
               pitch_set = 16'd4096;
               lp_set    = 16'($urandom);
               bq_set    = 1'b0;
            end
            1: begin
               pitch_set = 16'd64;
               lp_set    = '0;
               bq_set    = 1'b1;
            end
            2: begin
               pitch_set = 16'hffff;
               lp_set    = SAMPLE_MAX;
               bq_set    = 1'b1;
               b1_set    = SAMPLE_MIN;
               b2_set    = SAMPLE_MIN;
               a1_set    = SAMPLE_MIN;
               a2_set    = SAMPLE_MIN;
            end
            3: begin
               pitch_set = 16'($urandom_range(64, 65535));
               lp_set    = SAMPLE_MIN;
               bq_set    = 1'b0;
            end
            4: begin
               pitch_set = 16'($urandom_range(2048, 8192));
               lp_set    = 16'($urandom);
               bq_set    = 1'b1;
            end
            default: begin
               pitch_set = 16'($urandom_range(64, 65535));
               lp_set    = '0;
               bq_set    = 1'b1;
               b1_set    = SAMPLE_MAX;
               b2_set    = SAMPLE_MAX;
               a1_set    = SAMPLE_MAX;
               a2_set    = SAMPLE_MAX;
            end
         endcase
         write_settings(pitch_set, lp_set, bq_set, b1_set, b2_set, a1_set, a2_set);

         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            // mostly full-range samples, some at the rails, some close to the last one
            pick = $urandom_range(99);
            if (pick < 70) begin
               src = 16'($urandom);
            end else if (pick < 85) begin
               src = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
            end else begin
               src = last_src + 16'($urandom_range(511)) - 16'sd256;
            end
            send_beat(src, $urandom_range(99) < 4);
            last_src = src;
            // mid-phase hold-off until the result side has caught up
            if (i == BEATS_PER_PHASE / 2) drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
